>>> hdl/adsr_pkg.sv
// Shared widths, register indexes and controller/datapath command types for the ADSR block.
package adsr_pkg;

	localparam int COUNT_BITS  = 24;
	localparam int SAMPLE_BITS = 16;

	// Gain is unsigned Q16 with one integer bit, so unity fits exactly.
	localparam int FRAC_BITS = 16;
	localparam int GAIN_BITS = FRAC_BITS + 1;
	localparam logic [GAIN_BITS-1:0] UNITY = GAIN_BITS'(1) << FRAC_BITS;

	// Division: numerator is a count times a gain, quotient is below unity.
	localparam int QUO_BITS = GAIN_BITS;
	localparam int NUM_BITS = COUNT_BITS + GAIN_BITS;
	localparam int DIV_CNT_BITS = $clog2(QUO_BITS);

	// One multiplier serves both the ramp numerator and the final scaling.
	localparam int MUL_A_BITS = (COUNT_BITS > SAMPLE_BITS) ? COUNT_BITS : SAMPLE_BITS;
	localparam int MUL_BITS   = MUL_A_BITS + GAIN_BITS;
	localparam logic [MUL_BITS-1:0] ROUND_HALF = MUL_BITS'(1) << (FRAC_BITS - 1);

	// Configuration port.
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = (COUNT_BITS > GAIN_BITS) ? COUNT_BITS : GAIN_BITS;

	localparam logic [CFG_IDX_BITS-1:0] REG_ATTACK  = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DECAY   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_RELEASE = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_SUSTAIN = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLIP    = 3'd4;

	typedef struct packed {
		logic [COUNT_BITS-1:0] attack_length;
		logic [COUNT_BITS-1:0] decay_length;
		logic [COUNT_BITS-1:0] release_length;
		logic [GAIN_BITS-1:0]  sustain_level;
		logic [COUNT_BITS-1:0] clip_length;
	} cfg_t;

	// Commands from the controller to the datapath, one per step.
	typedef struct packed {
		logic load;
		logic bound;
		logic merge;
		logic select;
		logic mul_num;
		logic div_step;
		logic gain;
		logic mul_scale;
	} dp_cmd_t;

	typedef struct packed {
		logic div_last;
	} dp_status_t;

endpackage

>>> hdl/adsr_in_if.sv
// Input channel: one audio sample word with valid/ready handshake.
interface adsr_in_if
	import adsr_pkg::*;
();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

>>> hdl/adsr_out_if.sv
// Output channel: one shaped sample word with clip end flag and valid/ready handshake.
interface adsr_out_if
	import adsr_pkg::*;
();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clip_end;

	modport source (output valid, output sample_out, output clip_end, input ready);
	modport sink (input valid, input sample_out, input clip_end, output ready);
endinterface

>>> hdl/adsr_ctrl.sv
// Sequencer that steps the envelope datapath through one sample word.
module adsr_ctrl
	import adsr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic       out_free,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       idle,
	output logic       push
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BOUND,
		ST_MERGE,
		ST_SELECT,
		ST_MUL_NUM,
		ST_DIV,
		ST_GAIN,
		ST_MUL_SCALE,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE:      if (start) state_q <= ST_BOUND;
				ST_BOUND:     state_q <= ST_MERGE;
				ST_MERGE:     state_q <= ST_SELECT;
				ST_SELECT:    state_q <= ST_MUL_NUM;
				ST_MUL_NUM:   state_q <= ST_DIV;
				ST_DIV:       if (status.div_last) state_q <= ST_GAIN;
				ST_GAIN:      state_q <= ST_MUL_SCALE;
				ST_MUL_SCALE: state_q <= ST_EMIT;
				ST_EMIT:      if (out_free) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	assign idle = (state_q == ST_IDLE);
	assign push = (state_q == ST_EMIT) && out_free;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && start;
		cmd.bound     = (state_q == ST_BOUND);
		cmd.merge     = (state_q == ST_MERGE);
		cmd.select    = (state_q == ST_SELECT);
		cmd.mul_num   = (state_q == ST_MUL_NUM);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.gain      = (state_q == ST_GAIN);
		cmd.mul_scale = (state_q == ST_MUL_SCALE);
	end

endmodule

>>> hdl/adsr_dp.sv
// Envelope datapath: position counter, phase selection, shared multiplier and serial divider.
module adsr_dp
	import adsr_pkg::*;
(
	input  logic                          clk,
	input  logic                          arst_n,
	input  cfg_t                          cfg,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  dp_cmd_t                       cmd,
	output dp_status_t                    status,
	output logic signed [SAMPLE_BITS-1:0] res_sample,
	output logic                          res_last
);

	typedef enum logic [2:0] {
		PH_ATTACK,
		PH_DECAY,
		PH_SUSTAIN,
		PH_RELEASE,
		PH_ZERO
	} phase_t;

	logic [COUNT_BITS-1:0]   pos_q;
	logic [COUNT_BITS-1:0]   n_q;
	logic [COUNT_BITS-1:0]   idx_q;
	logic                    last_q;
	logic                    neg_q;
	logic [SAMPLE_BITS-1:0]  mag_q;
	logic [COUNT_BITS:0]     ss_q;
	logic [COUNT_BITS:0]     se_q;
	logic [GAIN_BITS-1:0]    s_q;
	phase_t                  phase_q;
	logic [COUNT_BITS-1:0]   opa_q;
	logic [GAIN_BITS-1:0]    opb_q;
	logic [COUNT_BITS-1:0]   dvs_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [QUO_BITS-1:0]     quo_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [GAIN_BITS-1:0]    gain_q;
	logic [MUL_BITS-1:0]     prod_q;

	// Position and clip bookkeeping for the word being accepted.
	logic [COUNT_BITS-1:0]  n_eff;
	logic [COUNT_BITS-1:0]  n_m1;
	logic                   is_last;
	logic [SAMPLE_BITS-1:0] raw;

	assign n_eff   = (cfg.clip_length == '0) ? COUNT_BITS'(1) : cfg.clip_length;
	assign n_m1    = n_eff - COUNT_BITS'(1);
	assign is_last = (pos_q >= n_m1);
	assign raw     = sample;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.load) begin
			pos_q <= is_last ? '0 : pos_q + COUNT_BITS'(1);
		end
	end

	// Phase selection.
	logic [COUNT_BITS:0]   idx_x;
	logic [COUNT_BITS-1:0] rel;
	phase_t                phase_d;

	assign idx_x = {1'b0, idx_q};
	assign rel   = idx_q - se_q[COUNT_BITS-1:0];

	always_comb begin
		if (idx_q < cfg.attack_length) begin
			phase_d = PH_ATTACK;
		end else if (idx_x < ss_q) begin
			phase_d = PH_DECAY;
		end else if (idx_x < se_q) begin
			phase_d = PH_SUSTAIN;
		end else if (cfg.release_length == '0 || rel >= cfg.release_length) begin
			phase_d = PH_ZERO;
		end else begin
			phase_d = PH_RELEASE;
		end
	end

	// Shared multiplier.
	logic [MUL_A_BITS-1:0] mul_x;
	logic [GAIN_BITS-1:0]  mul_y;
	logic [MUL_BITS-1:0]   product;

	assign mul_x   = cmd.mul_scale ? MUL_A_BITS'(mag_q) : MUL_A_BITS'(opa_q);
	assign mul_y   = cmd.mul_scale ? gain_q : opb_q;
	assign product = MUL_BITS'(mul_x) * MUL_BITS'(mul_y);

	// Restoring divider, one quotient bit per step.
	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] trial_diff;
	logic                trial_ge;

	assign trial      = {rem_q, quo_q[QUO_BITS-1]};
	assign trial_diff = trial - {1'b0, dvs_q};
	assign trial_ge   = (trial >= {1'b0, dvs_q});

	assign status.div_last = (cnt_q == DIV_CNT_BITS'(QUO_BITS - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= n_eff;
			last_q <= is_last;
			idx_q  <= is_last ? n_m1 : pos_q;
			neg_q  <= raw[SAMPLE_BITS-1];
			mag_q  <= raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
		end
		if (cmd.bound) begin
			ss_q <= {1'b0, cfg.attack_length} + {1'b0, cfg.decay_length};
			se_q <= (cfg.release_length >= n_q) ? '0
				: {1'b0, n_q - cfg.release_length};
			s_q  <= (cfg.sustain_level > UNITY) ? UNITY : cfg.sustain_level;
		end
		if (cmd.merge && se_q < ss_q) begin
			se_q <= ss_q;
		end
		if (cmd.select) begin
			phase_q <= phase_d;
			case (phase_d)
				PH_ATTACK: begin
					opa_q <= idx_q;
					opb_q <= UNITY;
					dvs_q <= cfg.attack_length;
				end
				PH_DECAY: begin
					opa_q <= idx_q - cfg.attack_length;
					opb_q <= UNITY - s_q;
					dvs_q <= cfg.decay_length;
				end
				PH_RELEASE: begin
					opa_q <= rel;
					opb_q <= s_q;
					dvs_q <= cfg.release_length;
				end
				default: begin
					opa_q <= '0;
					opb_q <= '0;
					dvs_q <= COUNT_BITS'(1);
				end
			endcase
		end
		if (cmd.mul_num) begin
			rem_q <= product[NUM_BITS-1:QUO_BITS];
			quo_q <= product[QUO_BITS-1:0];
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= trial_ge ? trial_diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[QUO_BITS-2:0], trial_ge};
			cnt_q <= cnt_q + DIV_CNT_BITS'(1);
		end
		if (cmd.gain) begin
			case (phase_q)
				PH_ATTACK:  gain_q <= quo_q;
				PH_DECAY:   gain_q <= UNITY - quo_q;
				PH_RELEASE: gain_q <= s_q - quo_q;
				PH_SUSTAIN: gain_q <= s_q;
				default:    gain_q <= '0;
			endcase
		end
		if (cmd.mul_scale) begin
			prod_q <= product;
		end
	end

	// Round half away from zero on the magnitude, then restore the sign.
	logic [MUL_BITS-1:0]    rounded;
	logic [SAMPLE_BITS-1:0] scaled;

	assign rounded    = prod_q + ROUND_HALF;
	assign scaled     = rounded[FRAC_BITS +: SAMPLE_BITS];
	assign res_sample = neg_q ? (~scaled + SAMPLE_BITS'(1)) : scaled;
	assign res_last   = last_q;

`ifndef NO_ASSERTIONS
	a_wrap_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && is_last |=> pos_q == '0)
		else $error("position did not wrap after the last sample of a clip");

	a_idx_in_clip: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> idx_q < n_q)
		else $error("envelope index lies outside the clip");
`endif

endmodule

>>> hdl/adsr_envelope_apply.sv
// Top level of the linear ADSR envelope: configuration registers, output register and sequencer.
//
// Each word taken on the audio channel is one signed sample of a clip. The block multiplies it
// by a linear attack, decay, sustain and release gain chosen from a position counter, and sends
// the rounded result with a clip end flag on the shaped channel.
// Both channels use valid/ready; a word moves at a rising edge where both are high.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register per edge, and
// should only be changed while no word is in flight. Writes to unknown indexes are ignored.
// Each word passes through the bound, merge, select, numerator multiply, divide, gain, scale
// and emit steps; the 17-step restoring divider forms the ramp gain. Input is not ready again
// until the current word's result has moved into the output register.
// The result sits in an output register, so the next input word is accepted while a finished
// word still waits; if the receiver stalls, the following word is held at its last step until
// the output register frees, and further input waits.
// Reset clears the position counter, empties the output register and returns the registers to
// zero lengths, unity sustain and a clip length of one. A change of configuration leaves the
// position counter where it is.
module adsr_envelope_apply
	import adsr_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	adsr_in_if.sink                  audio,
	adsr_out_if.source               shaped
);

	// Configuration register bank. Each register keeps the low bits of the data it is given.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_length  <= '0;
			cfg_q.decay_length   <= '0;
			cfg_q.release_length <= '0;
			cfg_q.sustain_level  <= UNITY;
			cfg_q.clip_length    <= COUNT_BITS'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ATTACK:  cfg_q.attack_length  <= cfg_data[COUNT_BITS-1:0];
				REG_DECAY:   cfg_q.decay_length   <= cfg_data[COUNT_BITS-1:0];
				REG_RELEASE: cfg_q.release_length <= cfg_data[COUNT_BITS-1:0];
				REG_SUSTAIN: cfg_q.sustain_level  <= cfg_data[GAIN_BITS-1:0];
				REG_CLIP:    cfg_q.clip_length    <= cfg_data[COUNT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer and datapath.
	dp_cmd_t                       cmd;
	dp_status_t                    status;
	logic                          idle;
	logic                          push;
	logic                          out_free;
	logic signed [SAMPLE_BITS-1:0] res_sample;
	logic                          res_last;

	adsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (audio.valid),
		.out_free (out_free),
		.status   (status),
		.cmd      (cmd),
		.idle     (idle),
		.push     (push)
	);

	adsr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.sample     (audio.sample_in),
		.cmd        (cmd),
		.status     (status),
		.res_sample (res_sample),
		.res_last   (res_last)
	);

	assign audio.ready = idle;

	// Output register. It can take a new word when it is empty or its word leaves this cycle.
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] sample_out_q;
	logic                          clip_end_q;

	assign out_free = !out_valid_q || shaped.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (shaped.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sample_out_q <= res_sample;
			clip_end_q   <= res_last;
		end
	end

	assign shaped.valid      = out_valid_q;
	assign shaped.sample_out = sample_out_q;
	assign shaped.clip_end   = clip_end_q;

`ifndef NO_ASSERTIONS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!out_valid_q || shaped.ready))
		else $error("result pushed over a word that has not been taken");

	a_accept_not_push: assert property (@(posedge clk) disable iff (!arst_n)
		(audio.valid && audio.ready) |-> !push)
		else $error("input accepted while a result was being pushed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(audio.valid && audio.ready) |=> !audio.ready)
		else $error("input still ready in the cycle after a word was taken");
`endif

endmodule

>>> dv/tb_adsr_envelope_apply.sv
// Self-checking testbench for the linear ADSR envelope block with a built-in gain predictor.
`timescale 1ns / 100ps

module tb_adsr_envelope_apply;
	import adsr_pkg::*;

	// An index that names no register; the block must ignore writes to it.
	localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COUNT_BITS-1:0] LENGTH_MAX = {COUNT_BITS{1'b1}};
	localparam int MAX_PAUSE = 8;
	localparam int RANDOM_WORDS = 700;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample_out;
		logic                          clip_end;
	} shaped_word_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	adsr_in_if  audio ();
	adsr_out_if shaped ();

	adsr_envelope_apply uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.audio     (audio),
		.shaped    (shaped)
	);

	// The predictor keeps its own copy of the registers and of the position counter.
	// The copy is updated as each register is written, which is safe because writes
	// only happen while no word is inside the block.
	logic [COUNT_BITS-1:0] attack_len;
	logic [COUNT_BITS-1:0] decay_len;
	logic [COUNT_BITS-1:0] release_len;
	logic [GAIN_BITS-1:0]  sustain_lvl;
	logic [COUNT_BITS-1:0] clip_len;
	logic [COUNT_BITS-1:0] clip_pos;

	logic signed [SAMPLE_BITS-1:0] sample_queue[$];
	shaped_word_t                  shaped_expected[$];

	int unsigned mismatch_count;
	int unsigned shaped_seen;
	int unsigned source_wait;
	int unsigned source_calm;
	int unsigned sink_wait;
	int unsigned sink_calm;
	int unsigned sink_pause;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Gain in unsigned Q16 at index i of a clip of n samples. Each phase of zero length
	// is skipped by its compare, so no division by zero can be reached. The sustain end
	// is pushed back to the decay end when the release would start before it.
	function automatic longint unsigned envelope_gain(input longint unsigned i,
			input longint unsigned n);
		longint unsigned a;
		longint unsigned d;
		longint unsigned r;
		longint unsigned s;
		longint unsigned decay_end;
		longint unsigned hold_end;
		a = attack_len;
		d = decay_len;
		r = release_len;
		s = (sustain_lvl > UNITY) ? UNITY : sustain_lvl;
		decay_end = a + d;
		hold_end = (r >= n) ? 0 : n - r;
		if (hold_end < decay_end)
			hold_end = decay_end;
		if (i < a)
			return (i << FRAC_BITS) / a;
		if (i < decay_end)
			return UNITY - ((i - a) * (UNITY - s)) / d;
		if (i < hold_end)
			return s;
		if (r == 0 || i - hold_end >= r)
			return 0;
		return s - (s * (i - hold_end)) / r;
	endfunction

	// Works out the shaped word for one accepted sample and advances the position.
	// A position at or beyond the last index is taken as the last sample of the clip,
	// which also covers a clip length lowered below the current position.
	function automatic void predict_shaped(input logic signed [SAMPLE_BITS-1:0] smp);
		longint signed   wide;
		longint unsigned n;
		longint unsigned mag;
		longint unsigned idx;
		longint unsigned scaled;
		logic            clip_done;
		shaped_word_t    w;
		n = (clip_len == 0) ? 1 : clip_len;
		wide = smp;
		mag = (wide < 0) ? -wide : wide;
		clip_done = (clip_pos >= n - 1);
		idx = clip_done ? n - 1 : clip_pos;
		// Rounding on the magnitude makes ties go away from zero for both signs.
		scaled = (mag * envelope_gain(idx, n) + (UNITY >> 1)) >> FRAC_BITS;
		w.sample_out = smp[SAMPLE_BITS-1] ? SAMPLE_BITS'(-scaled) : SAMPLE_BITS'(scaled);
		w.clip_end = clip_done;
		shaped_expected.insert(shaped_expected.size(), w);
		clip_pos = clip_done ? '0 : clip_pos + 1'b1;
	endfunction

	// Adds one sample to the tail of the sender's queue.
	function automatic void enqueue_sample(input logic signed [SAMPLE_BITS-1:0] smp);
		sample_queue.insert(sample_queue.size(), smp);
	endfunction

	// Pauses are drawn per word; now and then a calm stretch of back-to-back words follows.
	function automatic int unsigned draw_pause(input int unsigned calm);
		return (calm != 0) ? 0 : $urandom_range(0, MAX_PAUSE);
	endfunction

	function automatic int unsigned next_calm(input int unsigned calm);
		if (calm != 0)
			return calm - 1;
		return ($urandom_range(0, 39) == 0) ? 30 : 0;
	endfunction

	function automatic void note_mismatch(input string what, input longint exp_val,
			input longint got_val);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("shaped word %0d: %s expected %0d, got %0d", shaped_seen, what,
				exp_val, got_val);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return SAMPLE_MAX;
			1: return SAMPLE_MIN;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	// Phase lengths around a short clip, zero fairly often so that phases get skipped.
	function automatic logic [COUNT_BITS-1:0] short_length(input int unsigned n);
		return ($urandom_range(0, 4) == 0) ? '0 : COUNT_BITS'($urandom_range(0, n + 3));
	endfunction

	function automatic logic [COUNT_BITS-1:0] extreme_length();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return LENGTH_MAX;
			2: return COUNT_BITS'($urandom_range(0, 20));
			default: return COUNT_BITS'($urandom);
		endcase
	endfunction

	// Sustain values above unity are legal register contents and must act as unity.
	function automatic logic [GAIN_BITS-1:0] pick_sustain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return UNITY;
			2: return GAIN_BITS'($urandom);
			default: return GAIN_BITS'($urandom_range(0, 65536));
		endcase
	endfunction

	// Sender: the next word is presented once the current one has been taken and the
	// pause drawn for it has run out. Accepted words go straight to the predictor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio.valid <= 1'b0;
			audio.sample_in <= '0;
			source_wait <= 0;
			source_calm <= 0;
		end else begin
			if (audio.valid && audio.ready)
				predict_shaped(audio.sample_in);
			if (!audio.valid || audio.ready) begin
				if (source_wait != 0) begin
					audio.valid <= 1'b0;
					source_wait <= source_wait - 1;
				end else if (sample_queue.size() != 0) begin
					audio.valid <= 1'b1;
					audio.sample_in <= sample_queue.pop_front();
					source_wait <= draw_pause(source_calm);
					source_calm <= next_calm(source_calm);
				end else begin
					audio.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: every shaped word is checked against the oldest prediction, then ready
	// is held low for a freshly drawn number of cycles.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shaped.ready <= 1'b0;
			sink_wait <= 0;
			sink_calm <= 0;
		end else if (shaped.valid && shaped.ready) begin
			if (shaped_expected.size() == 0) begin
				note_mismatch("word with nothing predicted, sample_out", 0, shaped.sample_out);
			end else begin
				if (shaped.sample_out !== shaped_expected[0].sample_out)
					note_mismatch("sample_out", shaped_expected[0].sample_out,
						shaped.sample_out);
				if (shaped.clip_end !== shaped_expected[0].clip_end)
					note_mismatch("clip_end", shaped_expected[0].clip_end, shaped.clip_end);
				void'(shaped_expected.pop_front());
			end
			shaped_seen++;
			sink_pause = draw_pause(sink_calm);
			sink_wait <= sink_pause;
			sink_calm <= next_calm(sink_calm);
			shaped.ready <= (sink_pause == 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			shaped.ready <= (sink_wait == 1);
		end else begin
			shaped.ready <= 1'b1;
		end
	end

	// One register write per rising edge; the caller lowers the write enable afterwards
	// so that it is never dropped and raised again within one step.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_ATTACK:  attack_len = data[COUNT_BITS-1:0];
			REG_DECAY:   decay_len = data[COUNT_BITS-1:0];
			REG_RELEASE: release_len = data[COUNT_BITS-1:0];
			REG_SUSTAIN: sustain_lvl = data[GAIN_BITS-1:0];
			REG_CLIP:    clip_len = data[COUNT_BITS-1:0];
			default: ;
		endcase
	endtask

	// Writes every register, plus one stray write to an unused index. Bits above the
	// sustain field carry noise, which the block must drop.
	task automatic apply_settings(input logic [COUNT_BITS-1:0] a, input logic [COUNT_BITS-1:0] d,
			input logic [COUNT_BITS-1:0] r, input logic [GAIN_BITS-1:0] s,
			input logic [COUNT_BITS-1:0] n);
		write_reg(REG_ATTACK, a);
		write_reg(REG_DECAY, d);
		write_reg(REG_RELEASE, r);
		write_reg(REG_SUSTAIN, {CFG_DATA_BITS'($urandom) >> GAIN_BITS << GAIN_BITS} | s);
		write_reg(REG_CLIP, n);
		write_reg(REG_UNUSED, CFG_DATA_BITS'($urandom));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits until every queued sample has been taken and every shaped word has come back.
	// Each word always yields a result, so the block is idle once the last one has come back.
	task automatic drain();
		do
			@(negedge clk);
		while (sample_queue.size() != 0 || audio.valid || shaped_expected.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	initial begin
		int unsigned words_left;
		int unsigned batch;
		int unsigned n;
		logic [COUNT_BITS-1:0] clip_pick;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		audio.valid = 1'b0;
		audio.sample_in = '0;
		shaped.ready = 1'b0;
		attack_len = '0;
		decay_len = '0;
		release_len = '0;
		sustain_lvl = UNITY;
		clip_len = COUNT_BITS'(1);
		clip_pos = '0;
		mismatch_count = 0;
		shaped_seen = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: unity gain throughout a one-sample clip, with the sample extremes.
		enqueue_sample(SAMPLE_MAX);
		enqueue_sample(SAMPLE_MIN);
		enqueue_sample('0);
		enqueue_sample(SAMPLE_BITS'(-1));
		drain();

		// A clip that passes through attack, decay, sustain and release in turn.
		apply_settings(COUNT_BITS'(3), COUNT_BITS'(3), COUNT_BITS'(3), UNITY >> 1,
			COUNT_BITS'(12));
		for (int i = 0; i < 12; i++)
			enqueue_sample((i % 2) ? SAMPLE_MIN : SAMPLE_MAX);
		drain();

		// Half gain on odd samples lands exactly on rounding ties, which go away from zero.
		apply_settings('0, '0, '0, UNITY >> 1, COUNT_BITS'(3));
		enqueue_sample(SAMPLE_BITS'(1));
		enqueue_sample(SAMPLE_BITS'(-1));
		enqueue_sample(SAMPLE_BITS'(3));
		drain();

		// Sustain beyond unity and a clip length of zero, which acts as one.
		apply_settings('0, '0, '0, {GAIN_BITS{1'b1}}, '0);
		enqueue_sample(SAMPLE_BITS'(-12345));
		drain();

		// Run part way into a clip, then shorten the clip below the current position.
		apply_settings('0, '0, '0, UNITY, COUNT_BITS'(10));
		repeat (4) enqueue_sample(random_sample());
		drain();
		apply_settings('0, '0, '0, UNITY, COUNT_BITS'(2));
		enqueue_sample(SAMPLE_MAX);
		drain();

		// Random part: mostly short clips so that every phase and the wrap are reached
		// often, with occasional settings at the register extremes.
		words_left = RANDOM_WORDS;
		while (words_left != 0) begin
			if ($urandom_range(0, 7) == 0) begin
				case ($urandom_range(0, 3))
					0: clip_pick = '0;
					1: clip_pick = LENGTH_MAX;
					default: clip_pick = extreme_length();
				endcase
				apply_settings(extreme_length(), extreme_length(), extreme_length(),
					pick_sustain(), clip_pick);
				batch = $urandom_range(1, 20);
			end else begin
				n = $urandom_range(0, 40);
				apply_settings(short_length(n), short_length(n), short_length(n),
					pick_sustain(), COUNT_BITS'(n));
				batch = $urandom_range(1, 2 * n + 6);
			end
			if (batch > words_left)
				batch = words_left;
			repeat (batch) enqueue_sample(random_sample());
			words_left -= batch;
			drain();
		end

		repeat (30) @(posedge clk);
		if (shaped_expected.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("tb_adsr_envelope_apply: PASS");
		else
			$display("tb_adsr_envelope_apply: FAIL");
		$finish;
	end

	// Far beyond the slowest correct run, which needs well under half a millisecond.
	initial begin
		#5_000_000;
		$display("tb_adsr_envelope_apply: FAIL");
		$finish;
	end

endmodule
